@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top level of the slot table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tsie_pkg.sv @@
// types, constants and microcode program of the timed slot table
package tsie_pkg;

    localparam int SLOTS      = 8;
    localparam int KIND_COUNT = 64;
    localparam int TIME_BITS  = 48;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int INDEX_OUT_BITS = 3;
    localparam int KIND_BITS  = 6;
    localparam int STEP_BITS  = 3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SLOT_BITS-1:0] slot_idx_t;
    typedef logic [STEP_BITS-1:0] step_t;

    typedef struct packed {
        time_t                now;
        time_t                start_time;
        time_t                end_time;
        logic                 moving;
        logic [KIND_BITS-1:0] kind_code;
        logic [15:0]          room_id;
        logic signed [15:0]   data_first;
        logic signed [15:0]   data_second;
    } in_word_t;

    typedef struct packed {
        logic [INDEX_OUT_BITS-1:0] slot_index;
        logic                      evicted;
        time_t                     start_out;
        time_t                     end_out;
    } out_word_t;

    // datapath operations
    localparam logic [2:0] OP_ACCEPT    = 3'd0;
    localparam logic [2:0] OP_SCAN_MOVE = 3'd1;
    localparam logic [2:0] OP_DURATION  = 3'd2;
    localparam logic [2:0] OP_SHIFT     = 3'd3;
    localparam logic [2:0] OP_SCAN_FREE = 3'd4;
    localparam logic [2:0] OP_WRITE     = 3'd5;

    // jump conditions
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_NO_INPUT = 3'd1;
    localparam logic [2:0] COND_MORE     = 3'd2;
    localparam logic [2:0] COND_SCAN_ON  = 3'd3;
    localparam logic [2:0] COND_OUT_BUSY = 3'd4;

    // program steps
    localparam step_t ST_ACCEPT    = 3'd0;
    localparam step_t ST_SCAN_MOVE = 3'd1;
    localparam step_t ST_DURATION  = 3'd2;
    localparam step_t ST_SHIFT     = 3'd3;
    localparam step_t ST_SCAN_FREE = 3'd4;
    localparam step_t ST_WRITE     = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        step_t      jump_step;
        step_t      next_step;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic hit;
        logic out_busy;
        logic wr_fire;
    } flags_t;

    function automatic ctl_t rom_word(step_t step);
        ctl_t w;
        case (step)
            ST_ACCEPT:    w = '{OP_ACCEPT,    COND_NO_INPUT, ST_ACCEPT,    ST_SCAN_MOVE};
            ST_SCAN_MOVE: w = '{OP_SCAN_MOVE, COND_MORE,     ST_SCAN_MOVE, ST_DURATION};
            ST_DURATION:  w = '{OP_DURATION,  COND_NEVER,    ST_ACCEPT,    ST_SHIFT};
            ST_SHIFT:     w = '{OP_SHIFT,     COND_NEVER,    ST_ACCEPT,    ST_SCAN_FREE};
            ST_SCAN_FREE: w = '{OP_SCAN_FREE, COND_SCAN_ON,  ST_SCAN_FREE, ST_WRITE};
            ST_WRITE:     w = '{OP_WRITE,     COND_OUT_BUSY, ST_WRITE,     ST_ACCEPT};
            default:      w = '{OP_ACCEPT,    COND_NEVER,    ST_ACCEPT,    ST_ACCEPT};
        endcase
        return w;
    endfunction

    function automatic logic kind_valid(logic [KIND_BITS-1:0] k);
        return (k != '0) && ({1'b0, k} < (KIND_BITS+1)'(KIND_COUNT));
    endfunction

    function automatic logic [INDEX_OUT_BITS-1:0] index_out(slot_idx_t idx);
        logic [SLOT_BITS+INDEX_OUT_BITS-1:0] w;
        w = {{INDEX_OUT_BITS{1'b0}}, idx};
        return w[INDEX_OUT_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/tsie_seq.sv @@
// microcode sequencer: step counter, program rom and conditional jumps
module tsie_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  tsie_pkg::flags_t flags,
    output tsie_pkg::ctl_t   ctl
);

    tsie_pkg::step_t step_reg;
    tsie_pkg::step_t step_next;
    logic            take_jump;

    assign ctl = tsie_pkg::rom_word(step_reg);

    always_comb begin
        case (ctl.cond)
            tsie_pkg::COND_NEVER:    take_jump = 1'b0;
            tsie_pkg::COND_NO_INPUT: take_jump = !flags.in_valid;
            tsie_pkg::COND_MORE:     take_jump = !flags.last;
            tsie_pkg::COND_SCAN_ON:  take_jump = !flags.hit && !flags.last;
            tsie_pkg::COND_OUT_BUSY: take_jump = flags.out_busy;
            default:                 take_jump = 1'b0;
        endcase
        step_next = take_jump ? ctl.jump_step : ctl.next_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= tsie_pkg::ST_ACCEPT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/core/tsie_dp.sv @@
// datapath: slot table, scan registers, shift arithmetic and result register
module tsie_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsie_pkg::ctl_t      ctl,
    input  logic                s_valid,
    input  tsie_pkg::in_word_t  s_data,
    output tsie_pkg::flags_t    flags,
    output logic                m_valid,
    input  logic                m_ready,
    output tsie_pkg::out_word_t m_data
);

    // slot table
    logic [tsie_pkg::SLOTS-1:0]     vld_reg;
    logic [tsie_pkg::KIND_BITS-1:0] kind_mem  [tsie_pkg::SLOTS];
    tsie_pkg::time_t                start_mem [tsie_pkg::SLOTS];
    tsie_pkg::time_t                end_mem   [tsie_pkg::SLOTS];
    logic                           mov_mem   [tsie_pkg::SLOTS];
    logic [15:0]                    room_mem  [tsie_pkg::SLOTS];
    logic [31:0]                    pay_mem   [tsie_pkg::SLOTS];

    tsie_pkg::in_word_t  in_reg,        in_next;
    tsie_pkg::slot_idx_t idx_reg,       idx_next;
    logic                found_reg,     found_next;
    tsie_pkg::time_t     latest_reg,    latest_next;
    tsie_pkg::time_t     dur_reg,       dur_next;
    logic                shift_reg,     shift_next;
    tsie_pkg::slot_idx_t old_idx_reg,   old_idx_next;
    tsie_pkg::time_t     old_start_reg, old_start_next;
    tsie_pkg::slot_idx_t tgt_reg,       tgt_next;
    logic                evict_reg,     evict_next;
    tsie_pkg::out_word_t out_reg,       out_next;
    logic                out_valid_reg, out_valid_next;

    logic [tsie_pkg::KIND_BITS-1:0] rd_kind;
    tsie_pkg::time_t                rd_start;
    tsie_pkg::time_t                rd_end;
    logic                           rd_mov;
    logic                           last;
    logic                           free;
    logic                           cand_take;
    logic                           out_busy;
    logic                           wr_fire;

    // entries never written read as empty
    assign rd_kind  = vld_reg[idx_reg] ? kind_mem[idx_reg] : '0;
    assign rd_mov   = vld_reg[idx_reg] ? mov_mem[idx_reg]  : 1'b0;
    assign rd_start = vld_reg[idx_reg] ? start_mem[idx_reg] : '0;
    assign rd_end   = vld_reg[idx_reg] ? end_mem[idx_reg]   : '0;

    assign last      = (idx_reg == tsie_pkg::SLOT_BITS'(tsie_pkg::SLOTS - 1));
    assign free      = !tsie_pkg::kind_valid(rd_kind) || (in_reg.now >= rd_end);
    assign cand_take = (idx_reg == '0) || (rd_start < old_start_reg);
    assign out_busy  = out_valid_reg && !m_ready;
    assign wr_fire   = (ctl.op == tsie_pkg::OP_WRITE) && !out_busy;

    assign flags = '{in_valid: s_valid, last: last, hit: free,
                     out_busy: out_busy, wr_fire: wr_fire};

    always_comb begin
        in_next        = in_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        latest_next    = latest_reg;
        dur_next       = dur_reg;
        shift_next     = shift_reg;
        old_idx_next   = old_idx_reg;
        old_start_next = old_start_reg;
        tgt_next       = tgt_reg;
        evict_next     = evict_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        case (ctl.op)
            tsie_pkg::OP_ACCEPT: begin
                if (s_valid) begin
                    in_next     = s_data;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    latest_next = '0;
                end
            end
            tsie_pkg::OP_SCAN_MOVE: begin
                if (rd_mov && tsie_pkg::kind_valid(rd_kind)
                        && (!found_reg || rd_end > latest_reg)) begin
                    latest_next = rd_end;
                    found_next  = 1'b1;
                end
                idx_next = last ? '0 : idx_reg + 1'b1;
            end
            tsie_pkg::OP_DURATION: begin
                dur_next   = in_reg.end_time - in_reg.start_time;
                shift_next = found_reg && in_reg.moving
                             && tsie_pkg::kind_valid(in_reg.kind_code)
                             && (latest_reg > in_reg.start_time);
            end
            tsie_pkg::OP_SHIFT: begin
                if (shift_reg) begin
                    in_next.start_time = latest_reg;
                    in_next.end_time   = latest_reg + dur_reg;
                end
                idx_next = '0;
            end
            tsie_pkg::OP_SCAN_FREE: begin
                if (free) begin
                    tgt_next   = idx_reg;
                    evict_next = 1'b0;
                end else begin
                    if (cand_take) begin
                        old_idx_next   = idx_reg;
                        old_start_next = rd_start;
                    end
                    tgt_next   = cand_take ? idx_reg : old_idx_reg;
                    evict_next = 1'b1;
                end
                idx_next = last ? '0 : idx_reg + 1'b1;
            end
            tsie_pkg::OP_WRITE: begin
                if (wr_fire) begin
                    out_next.slot_index = tsie_pkg::index_out(tgt_reg);
                    out_next.evicted    = evict_reg;
                    out_next.start_out  = in_reg.start_time;
                    out_next.end_out    = in_reg.end_time;
                    out_valid_next      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (wr_fire) begin
                vld_reg[tgt_reg] <= 1'b1;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            kind_mem[tgt_reg]  <= in_reg.kind_code;
            start_mem[tgt_reg] <= in_reg.start_time;
            end_mem[tgt_reg]   <= in_reg.end_time;
            mov_mem[tgt_reg]   <= in_reg.moving;
            room_mem[tgt_reg]  <= in_reg.room_id;
            pay_mem[tgt_reg]   <= {in_reg.data_second, in_reg.data_first};
        end
    end

    always_ff @(posedge aclk) begin
        in_reg        <= in_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        latest_reg    <= latest_next;
        dur_reg       <= dur_next;
        shift_reg     <= shift_next;
        old_idx_reg   <= old_idx_next;
        old_start_reg <= old_start_next;
        tgt_reg       <= tgt_next;
        evict_reg     <= evict_next;
        out_reg       <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/core/timed_slot_insert_evict_oldest.sv @@
// top level of the timed slot table with free-first, oldest-start replacement
//
// s_ channel: one insert request per word (current time, start, end, kind, moving
// flag, room and two data words). s_ready is high only while the sequencer sits
// at its accept step, so one request is in work at a time.
// m_ channel: one result word per request (slot taken, eviction flag, stored start
// and end). the result sits in an output register; the next request may be taken
// while it still waits for m_ready.
// steps per request: 1 accept step, 8 steps over the slots for the latest moving
// end, 1 step for the duration, 1 step for the shift, 1 to 8 steps searching for a
// free slot (stops at the first free one), 1 write step. the slot scans read one
// slot per cycle.
// when the receiver stalls with a result still held, the write step waits and the
// table is not updated until the output register frees up.
// reset: synchronous, active low on aresetn; all slots read as empty afterwards and
// the sequencer returns to its accept step, with no result pending.
`include "assert_macros.svh"

module timed_slot_insert_evict_oldest (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsie_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tsie_pkg::out_word_t m_data
);

    // control word of the current step and status back to the sequencer
    tsie_pkg::ctl_t   ctl;
    tsie_pkg::flags_t flags;

    tsie_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctl     (ctl)
    );

    tsie_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .s_valid (s_valid),
        .s_data  (s_data),
        .flags   (flags),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // requests are only taken at the accept step
    assign s_ready = (ctl.op == tsie_pkg::OP_ACCEPT);

    // an accepted word always starts the moving-end scan
    `ASSERT_NEXT(a_accept_scan, s_valid && s_ready, ctl.op == tsie_pkg::OP_SCAN_MOVE, "accept did not start scan")
    // a table write never overruns a result still held
    `ASSERT_HOLDS(a_write_room, flags.wr_fire, !(m_valid && !m_ready), "result overwritten")
    // after the write the sequencer is back at the accept step with a result shown
    `ASSERT_NEXT(a_write_done, flags.wr_fire, s_ready && m_valid, "write did not complete")

endmodule
